### rtl/dbe_pkg.sv
// Shared types, codes and constants for the debounced two-button bit entry block.
package dbe_pkg;

    // Width of the tick count registers and counters.
    localparam int unsigned CNT_W = 16;

    // Width to which the result index and word are widened before the output register keeps their low bits.
    localparam int unsigned MAX_WORD_BITS = 16;

    // Default word length in bits.
    localparam int unsigned WORD_BITS_DEFAULT = 4;

    // Configuration port geometry: three 16-bit registers on a 32-bit bus at byte offsets 0, 4 and 8.
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    // Register reset values.
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [CNT_W-1:0] GAP_RESET      = 16'd20;

    // Entry phase.
    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_REL0 = 2'd1,
        PH_REL1 = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    // Event reported with each result.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_BIT     = 2'd1,
        EV_DONE    = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    // Per-tick control for one button debouncer.
    typedef struct packed {
        logic advance;  // a sample transfer happens this cycle
        logic scan;     // the button is sampled on this tick
        logic clear;    // a new bit entry starts after this tick
    } btn_ctrl_t;

endpackage

### rtl/debounced_two_button_bit_entry.sv
// Top level of the debounced two-button bit entry block.
//
// Each sample transfer is one 10 ms tick that carries the raw, active-low levels
// of two buttons, and it produces exactly one result transfer. While scanning,
// each button keeps a hold counter; a button held for debounce_ticks further
// ticks after its first pressed tick is qualified, button zero first. The block
// then waits for that button to be released, and the release enters a bit (0 for
// button zero, 1 for button one) into a WORD_BITS-bit word, least significant
// bit first. event_code reports 1 for an entered bit, 2 when the bit completes the
// word, 3 when a bit entry timed out (the word is cleared), and 0 otherwise.
// After every entered bit, gap_ticks ticks are ignored. Each bit entry may use
// timeout_ticks counted ticks; a timeout_ticks of zero makes every scanning tick
// report a timeout. The whole tick is evaluated in the cycle of its transfer and
// its result lands in a single output register, so one sample is taken every
// clock cycle; the only thing that holds the sample side back is a full result
// register whose transfer is stalled downstream. Registers are written through
// the APB-style port at byte offsets 0 (debounce_ticks), 4 (timeout_ticks) and
// 8 (gap_ticks) and should only be changed while no sample is in flight; a new
// value applies from the next tick.
module debounced_two_button_bit_entry
#(
    parameter int unsigned WORD_BITS = dbe_pkg::WORD_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbe_pkg::ADDR_W-1:0] paddr,
    input  logic [dbe_pkg::DATA_W-1:0] pwdata,
    output logic [dbe_pkg::DATA_W-1:0] prdata,
    output logic                       pready,

    // Sample channel.
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic                       pin_zero_level,
    input  logic                       pin_one_level,

    // Result channel.
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [1:0]                 event_code,
    output logic                       entered_bit,
    output logic [1:0]                 bit_position,
    output logic [3:0]                 word_value
);
    import dbe_pkg::*;

    // The bit index needs at least one bit, even for a one-bit word.
    localparam int unsigned IDX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int unsigned LAST_IDX = WORD_BITS - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] debounce_reg;
    logic [CNT_W-1:0] timeout_reg;
    logic [CNT_W-1:0] gap_ticks_reg;
    logic             cfg_write;
    logic [1:0]       cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            debounce_reg  <= DEBOUNCE_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            gap_ticks_reg <= GAP_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_DEBOUNCE: debounce_reg  <= pwdata[CNT_W-1:0];
                REG_TIMEOUT:  timeout_reg   <= pwdata[CNT_W-1:0];
                REG_GAP:      gap_ticks_reg <= pwdata[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE: prdata = DATA_W'(debounce_reg);
            REG_TIMEOUT:  prdata = DATA_W'(timeout_reg);
            REG_GAP:      prdata = DATA_W'(gap_ticks_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // The result register accepts a new result when it is empty or when its
    // current result is transferred in this same cycle.
    logic result_valid_reg;
    logic advance;

    assign sample_stall = result_valid_reg && result_stall;
    assign advance      = sample_valid && !sample_stall;

    // ------------------------------------------------------------------
    // Entry state
    // ------------------------------------------------------------------
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [CNT_W-1:0]     wait_reg;
    logic [CNT_W-1:0]     wait_next;
    logic [CNT_W-1:0]     gap_cnt_reg;
    logic [CNT_W-1:0]     gap_cnt_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Tick decisions shared by the next-state and result logic.
    logic                 q0;
    logic                 q1;
    logic [CNT_W:0]       wait_inc;
    logic                 to_start;
    logic                 to_late;
    logic                 rel_level;
    logic                 scan_to;
    logic                 ev_timeout;
    logic                 ev_accept;
    logic                 acc_bit;
    logic                 word_done;
    logic                 gap_left;
    logic [CNT_W-1:0]     gap_dec;
    logic [WORD_BITS-1:0] word_acc;

    assign wait_inc  = {1'b0, wait_reg} + 1'b1;
    assign to_start  = wait_reg >= timeout_reg;
    assign to_late   = wait_inc >= {1'b0, timeout_reg};
    assign rel_level = (phase_reg == PH_REL0) ? pin_zero_level : pin_one_level;

    // A scanning tick times out either before sampling, or after counting a
    // tick on which neither button qualified.
    assign scan_to = to_start || (!q0 && !q1 && to_late);

    always_comb
    begin
        ev_timeout = 1'b0;
        ev_accept  = 1'b0;
        case (phase_reg)
            PH_SCAN:          ev_timeout = scan_to;
            PH_REL0, PH_REL1:
            begin
                ev_timeout = to_late;
                ev_accept  = !to_late && rel_level;
            end
            default:          ;
        endcase
    end

    assign acc_bit   = (phase_reg == PH_REL1);
    assign word_done = ({1'b0, idx_reg} == (IDX_W + 1)'(LAST_IDX));
    assign word_acc  = word_reg | (WORD_BITS'(acc_bit) << idx_reg);
    assign gap_dec   = (gap_cnt_reg != '0) ? gap_cnt_reg - 1'b1 : gap_cnt_reg;
    assign gap_left  = (gap_dec != '0);

    // Button debouncers. Button one is only sampled when button zero does not
    // qualify, and a new entry clears both.
    btn_ctrl_t btn0_ctrl;
    btn_ctrl_t btn1_ctrl;

    assign btn0_ctrl.advance = advance;
    assign btn0_ctrl.scan    = (phase_reg == PH_SCAN) && !to_start;
    assign btn0_ctrl.clear   = ev_timeout || ev_accept;
    assign btn1_ctrl.advance = advance;
    assign btn1_ctrl.scan    = (phase_reg == PH_SCAN) && !to_start && !q0;
    assign btn1_ctrl.clear   = ev_timeout || ev_accept;

    dbe_button u_btn0
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (btn0_ctrl),
        .level          (pin_zero_level),
        .debounce_ticks (debounce_reg),
        .qualify        (q0)
    );

    dbe_button u_btn1
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (btn1_ctrl),
        .level          (pin_one_level),
        .debounce_ticks (debounce_reg),
        .qualify        (q1)
    );

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SCAN:
            begin
                if (scan_to) begin
                    phase_next = PH_SCAN;
                end else if (q0) begin
                    phase_next = PH_REL0;
                end else if (q1) begin
                    phase_next = PH_REL1;
                end
            end
            PH_REL0, PH_REL1:
            begin
                if (ev_timeout) begin
                    phase_next = PH_SCAN;
                end else if (ev_accept) begin
                    phase_next = (gap_ticks_reg == '0) ? PH_SCAN : PH_GAP;
                end
            end
            PH_GAP:
            begin
                if (!gap_left) begin
                    phase_next = PH_SCAN;
                end
            end
            default: phase_next = PH_SCAN;
        endcase
    end

    // Counters, word and the result of this tick.
    event_t           ev;
    logic             res_bit;
    logic [IDX_W-1:0] res_idx;
    logic [WORD_BITS-1:0] res_word;

    always_comb
    begin
        wait_next    = wait_reg;
        gap_cnt_next = gap_cnt_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        ev           = EV_NONE;
        res_bit      = 1'b0;
        res_idx      = idx_reg;
        res_word     = word_reg;

        if (ev_timeout) begin
            wait_next = '0;
            idx_next  = '0;
            word_next = '0;
            ev        = EV_TIMEOUT;
            res_word  = '0;
        end else if (ev_accept) begin
            wait_next    = '0;
            gap_cnt_next = gap_ticks_reg;
            ev           = word_done ? EV_DONE : EV_BIT;
            res_bit      = acc_bit;
            res_word     = word_acc;
            if (word_done) begin
                idx_next  = '0;
                word_next = '0;
            end else begin
                idx_next  = idx_reg + 1'b1;
                word_next = word_acc;
            end
        end else begin
            case (phase_reg)
                PH_GAP:           gap_cnt_next = gap_dec;
                PH_SCAN:
                begin
                    // Ticks that qualify a press are not counted.
                    if (!q0 && !q1) begin
                        wait_next = wait_inc[CNT_W-1:0];
                    end
                end
                PH_REL0, PH_REL1: wait_next = wait_inc[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_SCAN;
            wait_reg    <= '0;
            gap_cnt_reg <= '0;
            idx_reg     <= '0;
            word_reg    <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            gap_cnt_reg <= gap_cnt_next;
            idx_reg     <= idx_next;
            word_reg    <= word_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [MAX_WORD_BITS-1:0] res_idx_wide;
    logic [MAX_WORD_BITS-1:0] res_word_wide;
    logic [1:0]               event_code_reg;
    logic                     entered_bit_reg;
    logic [1:0]               bit_position_reg;
    logic [3:0]               word_value_reg;

    assign res_idx_wide  = MAX_WORD_BITS'(res_idx);
    assign res_word_wide = MAX_WORD_BITS'(res_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            event_code_reg   <= ev;
            entered_bit_reg  <= res_bit;
            bit_position_reg <= res_idx_wide[1:0];
            word_value_reg   <= res_word_wide[3:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign event_code   = event_code_reg;
    assign entered_bit  = entered_bit_reg;
    assign bit_position = bit_position_reg;
    assign word_value   = word_value_reg;

endmodule

### rtl/dbe_button.sv
// Hold counter and held flag of one button, with the press qualification.
module dbe_button
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dbe_pkg::btn_ctrl_t        ctrl,
    input  logic                      level,
    input  logic [dbe_pkg::CNT_W-1:0] debounce_ticks,
    output logic                      qualify
);
    import dbe_pkg::*;

    logic             held_reg;
    logic             held_next;
    logic [CNT_W-1:0] hold_reg;
    logic [CNT_W-1:0] hold_next;
    logic [CNT_W-1:0] hold_inc;

    // The counter saturates at its largest value.
    assign hold_inc = (hold_reg != {CNT_W{1'b1}}) ? hold_reg + 1'b1 : hold_reg;

    // A press qualifies once it has been held long enough after its first pressed tick.
    assign qualify = !level && held_reg && (hold_inc >= debounce_ticks);

    always_comb
    begin
        held_next = held_reg;
        hold_next = hold_reg;
        if (ctrl.advance) begin
            if (ctrl.clear) begin
                held_next = 1'b0;
                hold_next = '0;
            end else if (ctrl.scan) begin
                if (level) begin
                    held_next = 1'b0;
                    hold_next = '0;
                end else if (!held_reg) begin
                    held_next = 1'b1;
                    hold_next = '0;
                end else begin
                    hold_next = hold_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg <= 1'b0;
            hold_reg <= '0;
        end else begin
            held_reg <= held_next;
            hold_reg <= hold_next;
        end
    end

endmodule
